>>> hw/rtl/cfs_pkg.sv
// Shared types, constants and a helper function for the clipboard format sniffer.
`default_nettype none

package cfs_pkg;

    localparam int CNT_W        = 11;
    localparam int HDR_LEN      = 10;
    localparam int HDR_IDX_W    = 4;
    localparam int SAMPLE_BYTES = 1024;
    localparam int SAMPLE_W     = 17;
    localparam int PROD_W       = 18;
    localparam int THR_W        = 7;

    localparam logic [CNT_W-1:0] CNT_MAX = 11'd2047;
    localparam logic [7:0]       PCT_SCALE = 8'd100;
    localparam logic [16:0]      RECT_MAX  = 17'd32767;

    localparam logic [7:0] PNG_SIG [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                           8'h0D, 8'h0A, 8'h1A, 8'h0A};
    localparam logic [7:0] JPEG_SOI0 = 8'hFF;
    localparam logic [7:0] JPEG_SOI1 = 8'hD8;
    localparam logic [7:0] TIFF_LE   = 8'h49;
    localparam logic [7:0] TIFF_BE   = 8'h4D;
    localparam logic [7:0] TIFF_MAGIC = 8'd42;

    typedef enum logic [2:0] {
        FMT_NONE = 3'd0,
        FMT_TEXT = 3'd1,
        FMT_PICT = 3'd2,
        FMT_PNG  = 3'd3,
        FMT_JPEG = 3'd4,
        FMT_TIFF = 3'd5
    } fmt_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // a data word is taken this cycle
        logic calc;     // register products and signature flags
        logic load;     // pick the format, load the result, clear the object
    } cfs_cmd_t;

    function automatic logic is_printable(input logic [7:0] c);
        is_printable = (c >= 8'h20 && c <= 8'h7E) || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/clipboard_format_sniffer_top.sv
// Top level of the clipboard format sniffer: controller plus datapath.
// Throughput: one data word per cycle in S_RUN; intake pauses after each object
//   for the two classify steps (product register, then compare and select).
// After the last-marked word, the calc and decide steps load the format word.
// The output register lets the next object stream in while a result waits.
// Reset (rst_n, async, active low): counters clear, threshold returns to 80,
//   no result pending; header bytes are left as they are.
`default_nettype none

module clipboard_format_sniffer_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      format_code,
    input  wire logic       cfg_wr_en,
    input  wire logic [6:0] cfg_wr_data
);
    import cfs_pkg::*;

    cfs_cmd_t cmd;

    // Sequence intake, classify steps and the result handshake
    cfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Hold header, counts and threshold; compute and register the format word
    cfs_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .format_code (format_code)
    );

endmodule

`default_nettype wire

>>> hw/rtl/cfs_ctrl.sv
// Controller state machine: byte intake, classify sequencing, result handshake.
`default_nettype none

module cfs_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             last_byte,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output cfs_pkg::cfs_cmd_t     cmd
);
    import cfs_pkg::*;

    typedef enum logic [1:0] {
        S_RUN,
        S_CALC,
        S_DECIDE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready   = (state_reg == S_RUN);
    assign out_valid  = out_valid_reg;
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd.accept = in_valid && in_ready;
        cmd.calc   = (state_reg == S_CALC);
        cmd.load   = (state_reg == S_DECIDE) && out_free;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_RUN:
            begin
                if (in_valid && last_byte)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_last_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_byte) |=> (state_reg == S_CALC))
        else $error("last word did not start classification");

    a_calc_to_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC) |=> (state_reg == S_DECIDE))
        else $error("calc step did not advance to decide");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> out_valid_reg)
        else $error("loaded result not presented");

    a_rise_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DECIDE))
        else $error("result appeared outside decide");

endmodule

`default_nettype wire

>>> hw/rtl/cfs_datapath.sv
// Datapath: header capture, byte counters, ratio products and format selection.
`default_nettype none

module cfs_datapath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  cfs_pkg::cfs_cmd_t     cmd,
    input  wire logic [7:0]       data_byte,
    input  wire logic             cfg_wr_en,
    input  wire logic [6:0]       cfg_wr_data,
    output logic [2:0]            format_code
);
    import cfs_pkg::*;

    logic [7:0]        header_reg [HDR_LEN];
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic [CNT_W-1:0]  prn_reg, prn_next;
    logic              zero_reg, zero_next;
    logic [THR_W-1:0]  thr_reg;

    logic [PROD_W-1:0] prod_text_reg, prod_thr_reg;
    logic              pict_reg, png_reg, jpeg_reg, tiff_reg;
    fmt_t              fmt_reg;

    logic              scan_en;
    logic [CNT_W-1:0]  divisor;
    logic signed [15:0] top, left, bottom, right;
    logic signed [16:0] height, width;
    logic              rect_ok, png_hit, jpeg_hit, tiff_hit;

    assign format_code = fmt_reg;

    assign scan_en = !zero_reg && (SAMPLE_W'(scan_reg) < SAMPLE_W'(SAMPLE_BYTES))
                     && (scan_reg != CNT_MAX);

    always_comb
    begin
        pos_next  = pos_reg;
        scan_next = scan_reg;
        prn_next  = prn_reg;
        zero_next = zero_reg;
        if (cmd.load)
        begin
            pos_next  = '0;
            scan_next = '0;
            prn_next  = '0;
            zero_next = 1'b0;
        end
        else if (cmd.accept)
        begin
            if (pos_reg != CNT_MAX)
            begin
                pos_next = pos_reg + 1'b1;
            end
            if (scan_en)
            begin
                if (data_byte == 8'h00)
                begin
                    zero_next = 1'b1;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                    if (is_printable(data_byte))
                    begin
                        prn_next = prn_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            scan_reg <= '0;
            prn_reg  <= '0;
            zero_reg <= 1'b0;
            thr_reg  <= 7'd80;
        end
        else
        begin
            pos_reg  <= pos_next;
            scan_reg <= scan_next;
            prn_reg  <= prn_next;
            zero_reg <= zero_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && pos_reg < CNT_W'(HDR_LEN))
        begin
            header_reg[pos_reg[HDR_IDX_W-1:0]] <= data_byte;
        end
    end

    // floor(p*100/s) > t  <=>  p*100 >= (t+1)*s, with s forced to at least one
    assign divisor = (scan_reg == '0) ? CNT_W'(1) : scan_reg;

    always_comb
    begin
        top    = {header_reg[2], header_reg[3]};
        left   = {header_reg[4], header_reg[5]};
        bottom = {header_reg[6], header_reg[7]};
        right  = {header_reg[8], header_reg[9]};
        height = {bottom[15], bottom} - {top[15], top};
        width  = {right[15], right} - {left[15], left};
        rect_ok = !top[15] && !left[15]
                  && !height[16] && (height != '0) && ($unsigned(height) < RECT_MAX)
                  && !width[16] && (width != '0) && ($unsigned(width) < RECT_MAX);
        png_hit = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            if (header_reg[i] != PNG_SIG[i])
            begin
                png_hit = 1'b0;
            end
        end
        jpeg_hit = (header_reg[0] == JPEG_SOI0) && (header_reg[1] == JPEG_SOI1);
        tiff_hit = ((header_reg[0] == TIFF_LE) && (header_reg[1] == TIFF_LE)
                    && (header_reg[2] == TIFF_MAGIC) && (header_reg[3] == 8'h00))
                || ((header_reg[0] == TIFF_BE) && (header_reg[1] == TIFF_BE)
                    && (header_reg[2] == 8'h00) && (header_reg[3] == TIFF_MAGIC));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            prod_text_reg <= PROD_W'(prn_reg) * PROD_W'(PCT_SCALE);
            prod_thr_reg  <= (PROD_W'(thr_reg) + PROD_W'(1)) * PROD_W'(divisor);
            pict_reg      <= (pos_reg >= CNT_W'(10)) && rect_ok;
            png_reg       <= (pos_reg >= CNT_W'(8)) && png_hit;
            jpeg_reg      <= (pos_reg >= CNT_W'(8)) && jpeg_hit;
            tiff_reg      <= (pos_reg >= CNT_W'(8)) && tiff_hit;
        end
        if (cmd.load)
        begin
            if (prod_text_reg >= prod_thr_reg)
                fmt_reg <= FMT_TEXT;
            else if (pict_reg)
                fmt_reg <= FMT_PICT;
            else if (png_reg)
                fmt_reg <= FMT_PNG;
            else if (jpeg_reg)
                fmt_reg <= FMT_JPEG;
            else if (tiff_reg)
                fmt_reg <= FMT_TIFF;
            else
                fmt_reg <= FMT_NONE;
        end
    end

endmodule

`default_nettype wire
